// ===== sv/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants for the LFU slot replacement block
// Entry layout of the slot memory, outcome codes and the control and status
// structs that pass between the sequencer and the scan unit.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int SLOTS_DEFAULT  = 20;
  localparam int MAX_ID_DEFAULT = 100;

  localparam int ID_W       = 7;
  localparam int COUNT_W    = 16;
  localparam int STAMP_W    = 32;
  localparam int SLOT_OUT_W = 5;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(20);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OUT_HIT      = 2'd0,
    OUT_PLACED   = 2'd1,
    OUT_REPLACED = 2'd2
  } outcome_t;

  // One slot of the table as it sits in memory.
  typedef struct packed {
    logic [ID_W-1:0]    ident;
    logic [COUNT_W-1:0] uses;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // Control from the sequencer to the scan unit.
  typedef struct packed {
    logic start;    // new candidate taken, clear the running results
    logic sample;   // read data of one slot is present this cycle
    logic present;  // valid bit of that slot
    logic active;   // slot lies below the active slot count
  } scan_ctl_t;

  // Status from the scan unit back to the sequencer.
  typedef struct packed {
    logic hit;
    logic free;
    logic vic_have;
  } scan_res_t;

endpackage

// ===== sv/lfu_ram.sv =====
// ----------------------------------------------------------------------------
// lfu_ram: slot entry memory
// Single write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int DEPTH = 20,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  lfu_pkg::entry_t  wdata,
  input  logic [AW-1:0]    raddr,
  output lfu_pkg::entry_t  rdata
);
  import lfu_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/lfu_scan.sv =====
// ----------------------------------------------------------------------------
// lfu_scan: per-slot search unit
// Looks at one slot per cycle and keeps the first hit, the first free active
// slot and the best replacement victim found so far.
// ----------------------------------------------------------------------------
module lfu_scan #(
  parameter int SLOTS = 20,
  parameter int IW    = 5
) (
  input  logic                        clk,
  input  lfu_pkg::scan_ctl_t          ctl,
  input  logic [IW-1:0]               slot,
  input  lfu_pkg::entry_t             entry,
  input  logic [lfu_pkg::ID_W-1:0]    cand_id,
  input  logic [lfu_pkg::STAMP_W-1:0] seq,
  output lfu_pkg::scan_res_t          res,
  output logic [IW-1:0]               hit_slot,
  output lfu_pkg::entry_t             hit_entry,
  output logic [IW-1:0]               free_slot,
  output logic [IW-1:0]               vic_slot,
  output lfu_pkg::entry_t             vic_entry
);
  import lfu_pkg::*;

  logic [STAMP_W-1:0] age;
  logic [STAMP_W-1:0] vic_age;
  logic               take_hit;
  logic               take_free;
  logic               take_vic;

  // Age is taken modulo the stamp width so the order survives wrapping.
  assign age       = seq - entry.stamp;
  assign take_hit  = ctl.sample && !res.hit && ctl.present && (entry.ident == cand_id);
  assign take_free = ctl.sample && !res.free && ctl.active && !ctl.present;
  assign take_vic  = ctl.sample && ctl.active && ctl.present &&
                     (!res.vic_have || (entry.uses < vic_entry.uses) ||
                      ((entry.uses == vic_entry.uses) && (age > vic_age)));

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      res <= '0;
    end else begin
      if (take_hit) begin
        res.hit   <= 1'b1;
        hit_slot  <= slot;
        hit_entry <= entry;
      end
      if (take_free) begin
        res.free  <= 1'b1;
        free_slot <= slot;
      end
      if (take_vic) begin
        res.vic_have <= 1'b1;
        vic_slot     <= slot;
        vic_entry    <= entry;
        vic_age      <= age;
      end
    end
  end

endmodule

// ===== sv/lfu_slot_replacement.sv =====
// ----------------------------------------------------------------------------
// lfu_slot_replacement: least-frequently-used slot table, oldest first on ties
// Counts candidate ids already held, places new ones in the lowest free slot
// and otherwise replaces the entry with the lowest count, oldest first.
// ----------------------------------------------------------------------------
//
//   Channel     Handshake             Payload
//   candidate   cand_valid/cand_stall candidate_id
//   result      res_valid/res_stall   slot_index, outcome, evicted_id, new_count
//   config      cfg_wen               cfg_wdata (slots_in_use)
//
// Each accepted candidate goes through these steps in order: taking the
// transfer, one memory read per slot, catching the last read data, writing
// the entry back and handing the result to the output register. The single
// read port of the slot memory is why the slots are read one at a time.
// Reset clears the valid bits, the insertion counter and the sequencer, so
// the memory needs no clearing pass. A stalled result holds in the output
// register; the next candidate may be taken meanwhile and waits for it only
// at its own final step. A candidate id of zero or above MAX_ID is taken and
// dropped without a result.
// ----------------------------------------------------------------------------
module lfu_slot_replacement #(
  parameter int SLOTS  = lfu_pkg::SLOTS_DEFAULT,
  parameter int MAX_ID = lfu_pkg::MAX_ID_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wen,
  input  logic [lfu_pkg::CFG_W-1:0]      cfg_wdata,
  // candidate channel
  input  logic                           cand_valid,
  output logic                           cand_stall,
  input  logic [lfu_pkg::ID_W-1:0]       candidate_id,
  // result channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic [lfu_pkg::SLOT_OUT_W-1:0] slot_index,
  output logic [1:0]                     outcome,
  output logic [lfu_pkg::ID_W-1:0]       evicted_id,
  output logic [lfu_pkg::COUNT_W-1:0]    new_count
);
  import lfu_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
  localparam logic [7:0]    SLOTS8    = 8'(SLOTS);
  localparam logic [7:0]    MAX_ID8   = 8'(MAX_ID);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE,
    ST_RESULT
  } state_t;

  state_t             state;
  logic [CFG_W-1:0]   slots_in_use;
  logic [SLOTS-1:0]   valid_q;
  logic [STAMP_W-1:0] seq;
  logic [ID_W-1:0]    id_q;
  logic [CW-1:0]      n_q;
  logic [IW-1:0]      addr_q;
  logic [IW-1:0]      rd_slot_q;
  logic               sample_q;

  // Result waiting for the output register.
  logic [IW-1:0]      hold_slot;
  outcome_t           hold_outcome;
  logic [ID_W-1:0]    hold_evict;
  logic [COUNT_W-1:0] hold_count;

  logic       id_ok;
  logic [7:0] n_next;

  scan_ctl_t  scan_ctl;
  scan_res_t  scan_res;
  entry_t     rd_entry;
  entry_t     hit_entry;
  entry_t     vic_entry;
  entry_t     wr_entry;
  logic [IW-1:0] hit_slot;
  logic [IW-1:0] free_slot;
  logic [IW-1:0] vic_slot;
  logic [IW-1:0] target;
  logic          mem_we;
  outcome_t      step_outcome;
  logic [COUNT_W-1:0] hit_count;

  // The sequencer only takes a candidate while idle.
  assign cand_stall = (state != ST_IDLE);
  assign id_ok      = (candidate_id != '0) && ({1'b0, candidate_id} <= MAX_ID8);

  // A slot count of zero acts as one, and one above SLOTS acts as SLOTS.
  always_comb begin
    n_next = {3'b000, slots_in_use};
    if (n_next == 8'd0) begin
      n_next = 8'd1;
    end else if (n_next > SLOTS8) begin
      n_next = SLOTS8;
    end
  end

  assign scan_ctl.start   = (state == ST_IDLE) && cand_valid;
  assign scan_ctl.sample  = sample_q;
  assign scan_ctl.present = valid_q[rd_slot_q];
  assign scan_ctl.active  = (8'(rd_slot_q) < 8'(n_q));

  lfu_ram #(
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (target),
    .wdata (wr_entry),
    .raddr (addr_q),
    .rdata (rd_entry)
  );

  lfu_scan #(
    .SLOTS (SLOTS),
    .IW    (IW)
  ) u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .slot      (rd_slot_q),
    .entry     (rd_entry),
    .cand_id   (id_q),
    .seq       (seq),
    .res       (scan_res),
    .hit_slot  (hit_slot),
    .hit_entry (hit_entry),
    .free_slot (free_slot),
    .vic_slot  (vic_slot),
    .vic_entry (vic_entry)
  );

  // Write-back: a hit bumps the count in place, anything else installs the
  // candidate with a count of one and the current insertion stamp.
  assign hit_count = (hit_entry.uses == COUNT_MAX) ? hit_entry.uses
                                                   : hit_entry.uses + COUNT_W'(1);

  always_comb begin
    if (scan_res.hit) begin
      step_outcome   = OUT_HIT;
      target         = hit_slot;
      wr_entry       = hit_entry;
      wr_entry.uses  = hit_count;
    end else begin
      step_outcome   = scan_res.free ? OUT_PLACED : OUT_REPLACED;
      target         = scan_res.free ? free_slot : vic_slot;
      wr_entry.ident = id_q;
      wr_entry.uses  = COUNT_W'(1);
      wr_entry.stamp = seq;
    end
  end

  assign mem_we = (state == ST_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= CFG_RESET;
      valid_q      <= '0;
      seq          <= '0;
      sample_q     <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cfg_wen) begin
        slots_in_use <= cfg_wdata;
      end

      sample_q  <= (state == ST_SCAN);
      rd_slot_q <= addr_q;

      // In the result step the output register is handled by the step itself.
      if (res_valid && !res_stall && (state != ST_RESULT)) begin
        res_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cand_valid && id_ok) begin
            id_q   <= candidate_id;
            n_q    <= n_next[CW-1:0];
            addr_q <= '0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          addr_q <= addr_q + IW'(1);
          if (addr_q == LAST_SLOT) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          valid_q[target] <= 1'b1;
          if (!scan_res.hit) begin
            seq <= seq + STAMP_W'(1);
          end
          hold_slot    <= target;
          hold_outcome <= step_outcome;
          hold_evict   <= (step_outcome == OUT_REPLACED) ? vic_entry.ident : '0;
          hold_count   <= wr_entry.uses;
          state        <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!res_valid || !res_stall) begin
            res_valid  <= 1'b1;
            slot_index <= SLOT_OUT_W'(hold_slot);
            outcome    <= hold_outcome;
            evicted_id <= hold_evict;
            new_count  <= hold_count;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A new result only ever comes out of the final step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_RESULT))
    else $error("result raised outside the result step");

  // A counted hit leaves the insertion counter alone.
  a_hit_keeps_seq: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && scan_res.hit) |=> (seq == $past(seq)))
    else $error("insertion counter moved on a hit");

  // Placement only ever goes into a slot that was empty.
  a_place_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !scan_res.hit && scan_res.free) |-> !valid_q[free_slot])
    else $error("placement into an occupied slot");

  // Replacement needs a victim, and the victim slot must be occupied.
  a_victim_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !scan_res.hit && !scan_res.free) |->
      (scan_res.vic_have && valid_q[vic_slot]))
    else $error("replacement without an occupied victim");

endmodule

// ===== tb/sv/lfu_slot_replacement_tb.sv =====
// ----------------------------------------------------------------------------
// lfu_slot_replacement_tb: self-checking bench for the LFU slot table
// A scoreboard class mirrors the slot table and predicts every result. Directed
// candidates and random candidates run through several slot-count settings.
// The bench idles and stalls at random, and holds the result side off once.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [lfu_pkg::SLOT_OUT_W-1:0] slot;
  lfu_pkg::outcome_t              oc;
  logic [lfu_pkg::ID_W-1:0]       evicted;
  logic [lfu_pkg::COUNT_W-1:0]    count;
} slot_result_t;

// Shadow copy of the slot table, with the queue of results still owed.
class slot_table_tracker;
  logic [lfu_pkg::ID_W-1:0]    ident [lfu_pkg::SLOTS_DEFAULT];
  logic [lfu_pkg::COUNT_W-1:0] uses  [lfu_pkg::SLOTS_DEFAULT];
  logic [lfu_pkg::STAMP_W-1:0] stamp [lfu_pkg::SLOTS_DEFAULT];
  bit                          held  [lfu_pkg::SLOTS_DEFAULT];
  logic [lfu_pkg::STAMP_W-1:0] seq;
  logic [lfu_pkg::CFG_W-1:0]   slots_reg;
  slot_result_t                owed [$];
  int                          errors;

  function new();
    for (int i = 0; i < lfu_pkg::SLOTS_DEFAULT; i++) begin
      ident[i] = '0;
      uses[i]  = '0;
      stamp[i] = '0;
      held[i]  = 1'b0;
    end
    seq       = '0;
    slots_reg = lfu_pkg::CFG_RESET;
    errors    = 0;
  endfunction

  function void set_slots(input logic [lfu_pkg::CFG_W-1:0] v);
    slots_reg = v;
  endfunction

  function int outstanding();
    return owed.size();
  endfunction

  // Works out the result of one accepted candidate and updates the table.
  function void note_candidate(input logic [lfu_pkg::ID_W-1:0] id);
    int                          n;
    int                          pick;
    bit                          found;
    logic [lfu_pkg::COUNT_W-1:0] best_uses;
    logic [lfu_pkg::STAMP_W-1:0] best_age;
    logic [lfu_pkg::STAMP_W-1:0] age;
    slot_result_t                r;
    if (id == 0 || id > lfu_pkg::MAX_ID_DEFAULT) return;
    n = slots_reg;
    if (n < 1) n = 1;
    if (n > lfu_pkg::SLOTS_DEFAULT) n = lfu_pkg::SLOTS_DEFAULT;
    found     = 1'b0;
    pick      = 0;
    best_uses = '0;
    best_age  = '0;
    r.evicted = '0;
    // A hit may sit in any valid slot, active or not.
    for (int i = 0; i < lfu_pkg::SLOTS_DEFAULT; i++) begin
      if (!found && held[i] && ident[i] == id) begin
        found = 1'b1;
        pick  = i;
      end
    end
    if (found) begin
      if (uses[pick] != lfu_pkg::COUNT_MAX) uses[pick] = uses[pick] + 1'b1;
      r.oc    = lfu_pkg::OUT_HIT;
      r.count = uses[pick];
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && !held[i]) begin
          found = 1'b1;
          pick  = i;
        end
      end
      if (found) begin
        r.oc = lfu_pkg::OUT_PLACED;
      end else begin
        // Lowest count loses; on a tie the entry placed longest ago loses.
        for (int i = 0; i < n; i++) begin
          age = seq - stamp[i];
          if (i == 0 || uses[i] < best_uses || (uses[i] == best_uses && age > best_age)) begin
            best_uses = uses[i];
            best_age  = age;
            pick      = i;
          end
        end
        r.evicted = ident[pick];
        r.oc      = lfu_pkg::OUT_REPLACED;
      end
      ident[pick] = id;
      uses[pick]  = 1;
      stamp[pick] = seq;
      held[pick]  = 1'b1;
      seq         = seq + 1'b1;
      r.count     = 1;
    end
    r.slot = lfu_pkg::SLOT_OUT_W'(pick);
    owed.push_back(r);
  endfunction

  function void compare_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_result(input logic [lfu_pkg::SLOT_OUT_W-1:0] slot,
                             input logic [1:0]                     oc,
                             input logic [lfu_pkg::ID_W-1:0]       evicted,
                             input logic [lfu_pkg::COUNT_W-1:0]    count);
    slot_result_t w;
    if (owed.size() == 0) begin
      $display("%0t: unexpected result transfer, expected none, actual slot %0d count %0d",
               $time, slot, count);
      errors++;
      return;
    end
    w = owed.pop_front();
    compare_field("slot_index", 32'(w.slot), 32'(slot));
    compare_field("outcome", 32'(w.oc), 32'(oc));
    compare_field("evicted_id", 32'(w.evicted), 32'(evicted));
    compare_field("new_count", 32'(w.count), 32'(count));
  endfunction
endclass

module lfu_slot_replacement_tb;
  import lfu_pkg::*;

  // Number of valid candidates per random phase, eight phases in all.
  localparam int PHASE_ITEMS = 250;
  // Cycles to let a dropped candidate clear the block before a register write.
  localparam int SETTLE      = 40;
  // The receiver holds off once, after HOLD_AT results, for a stretch set by HOLD_LEN.
  localparam int HOLD_AT     = 100;
  localparam int HOLD_LEN    = 400;
  // Cycles without any transfer or register write before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  cand_valid = 1'b0;
  logic                  cand_stall;
  logic [ID_W-1:0]       candidate_id = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic [SLOT_OUT_W-1:0] slot_index;
  logic [1:0]            outcome;
  logic [ID_W-1:0]       evicted_id;
  logic [COUNT_W-1:0]    new_count;

  // Set during a stretch of the run in which neither side idles.
  logic                  quiet_run = 1'b0;
  int                    res_taken = 0;
  int                    hold_left = 0;
  bit                    hold_done = 1'b0;
  int                    idle_cycles = 0;

  slot_table_tracker     sb;

  lfu_slot_replacement u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .cand_valid   (cand_valid),
    .cand_stall   (cand_stall),
    .candidate_id (candidate_id),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .slot_index   (slot_index),
    .outcome      (outcome),
    .evicted_id   (evicted_id),
    .new_count    (new_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every transfer on either channel is observed here, on the clock edge at
  // which it takes place. A candidate is noted before a result is checked, but
  // the two never belong to the same item, since a result follows its scan steps.
  always @(posedge clk) begin
    if (!rst) begin
      if (cand_valid && !cand_stall) sb.note_candidate(candidate_id);
      if (res_valid && !res_stall) sb.check_result(slot_index, outcome, evicted_id, new_count);
    end
  end

  // Result side. It stalls at random, except in the quiet stretch, and once it
  // holds off for a long stretch so that the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      hold_left <= 0;
      res_taken <= 0;
    end else begin
      if (res_valid && !res_stall) res_taken <= res_taken + 1;
      if (!hold_done && res_taken == HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        res_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !quiet_run && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Watchdog: any transfer or register write restarts the count.
  always @(posedge clk) begin
    if (rst || cfg_wen || (cand_valid && !cand_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one candidate and returns at the edge of its transfer. Valid is left
  // high so that a following candidate goes out back to back; it is lowered
  // only when the sender idles or pauses.
  task automatic send_candidate(input logic [ID_W-1:0] id);
    while (!quiet_run && $urandom_range(0, 99) < 16) begin
      cand_valid   <= 1'b0;
      candidate_id <= ID_W'($urandom);
      @(posedge clk);
    end
    cand_valid   <= 1'b1;
    candidate_id <= id;
    do @(posedge clk); while (cand_stall);
  endtask

  // The sender pauses until every expected result has been taken, then lets
  // a further number of cycles pass so that any dropped candidate clears.
  task automatic drain(input int extra);
    cand_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (extra) @(posedge clk);
  endtask

  // Writes the slot count once the block has gone idle.
  task automatic write_slots(input logic [CFG_W-1:0] v);
    drain(SETTLE);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cfg_wdata <= CFG_W'($urandom);
    sb.set_slots(v);
  endtask

  // Mostly ids from a small set reaching just above the active slot count, which gives
  // plenty of hits, ties and replacements; some from the full range; a few out
  // of range, which the block must drop.
  function automatic logic [ID_W-1:0] pick_candidate(input int active);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return '0;
    if (r < 6) return ID_W'($urandom_range(MAX_ID_DEFAULT + 1, (1 << ID_W) - 1));
    if (r < 70) return ID_W'($urandom_range(1, active + 4));
    return ID_W'($urandom_range(1, MAX_ID_DEFAULT));
  endfunction

  initial begin : stimulus
    int               phase_slots [8];
    int               active;
    int               sent;
    logic [ID_W-1:0]  id;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Four active slots: placement, the id extremes and the
    // dropped ids, hits, then replacement with the oldest entry losing a tie,
    // and an evicted id returning at count one.
    write_slots(CFG_W'(4));
    send_candidate(ID_W'(1));
    send_candidate(ID_W'(100));
    send_candidate(ID_W'(0));
    send_candidate(ID_W'(127));
    send_candidate(ID_W'(101));
    send_candidate(ID_W'(1));
    send_candidate(ID_W'(64));
    send_candidate(ID_W'(63));
    send_candidate(ID_W'(100));
    send_candidate(ID_W'(50));
    send_candidate(ID_W'(64));
    // Lowered slot count: an entry above it is still counted in place, but
    // replacement only looks at the two active slots.
    write_slots(CFG_W'(2));
    send_candidate(ID_W'(64));
    send_candidate(ID_W'(90));
    // A count of zero acts as one slot.
    write_slots(CFG_W'(0));
    send_candidate(ID_W'(91));
    send_candidate(ID_W'(92));
    // The largest setting acts as the full table.
    write_slots(CFG_W'(31));
    send_candidate(ID_W'(93));
    send_candidate(ID_W'(94));
    send_candidate(ID_W'(1));

    // Random part, one slot-count setting per phase. The fourth phase runs
    // with no idling on either side.
    phase_slots = '{20, 1, 7, 31, 0, 13, 21, 20};
    phase_slots[7] = $urandom_range(2, 19);
    for (int p = 0; p < 8; p++) begin
      write_slots(CFG_W'(phase_slots[p]));
      quiet_run <= (p == 3);
      active = (phase_slots[p] < 1) ? 1 :
               (phase_slots[p] > SLOTS_DEFAULT) ? SLOTS_DEFAULT : phase_slots[p];
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        id = pick_candidate(active);
        send_candidate(id);
        if (id >= 1 && id <= MAX_ID_DEFAULT) sent++;
      end
    end

    drain(2 * SETTLE);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
